// File: design/assert_macros.svh
// Assertion macros for the keypad code lock design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KCL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define KCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/kcl_pkg.sv
// Types, codes and the keypad decode table for the keypad code lock.
`timescale 1ns / 1ps

package kcl_pkg;

   // Key codes beyond the decimal digits.
   localparam logic [3:0] KEY_STAR  = 4'd10;
   localparam logic [3:0] KEY_HASH  = 4'd11;
   localparam logic [3:0] KEY_EMPTY = 4'd15;

   // Column code that no keypad column uses.
   localparam logic [1:0] COL_NONE = 2'd3;

   // Reset values of the configuration registers and the lock state.
   localparam logic [9:0]  DEBOUNCE_RESET = 10'd100;
   localparam logic [9:0]  FLASH_RESET    = 10'd400;
   localparam logic [15:0] SERVICE_RESET  = 16'h5592;
   localparam logic [10:0] HOLD_RESET     = 11'd100;
   localparam logic [15:0] USER_RESET     = 16'h1476;

   // Steady lamp patterns.
   localparam logic [2:0] LEDS_SERVICE = 3'd7;
   localparam logic [2:0] LEDS_OFF     = 3'd0;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_FLASH    = 2'd1,
      CSR_SERVICE  = 2'd2
   } csr_index_type;

   // Outcome of one press.
   typedef enum logic [3:0] {
      EV_IGNORED     = 4'd0,
      EV_DIGIT       = 4'd1,
      EV_NONE        = 4'd2,
      EV_OPEN        = 4'd3,
      EV_WRONG       = 4'd4,
      EV_SERVICE     = 4'd5,
      EV_CHANGED     = 4'd6,
      EV_CLEARED     = 4'd7,
      EV_CANCEL_HASH = 4'd8,
      EV_CANCEL_STAR = 4'd9
   } event_type;

   // One keypad press, last field in the lowest bits.
   typedef struct packed {
      logic [31:0] now_ms;
      logic [1:0]  key_row;
      logic [1:0]  key_column;
   } press_type;

   // One result item, last field in the lowest bits.
   typedef struct packed {
      logic [15:0] entry_digits;
      logic [2:0]  entry_count;
      logic [2:0]  steady_leds;
      event_type   event_res;
      logic [3:0]  key_value;
      logic        accepted;
   } result_type;

   // Configuration registers.
   typedef struct packed {
      logic [9:0]  debounce_ms;
      logic [9:0]  flash_ms;
      logic [15:0] service_code;
   } cfg_type;

   // Scalar lock state handed between the top level and the step logic.
   typedef struct packed {
      logic        check_armed;
      logic        in_service;
      logic [31:0] last_time;
      logic [10:0] hold_window;
   } ctrl_type;

   // Keypad matrix: column and row to key code.
   function automatic logic [3:0] key_decode(input logic [1:0] col, input logic [1:0] row);
      logic [3:0] key;
      key = KEY_EMPTY;
      unique case (col)
         2'd0: begin
            unique case (row)
               2'd0: key = 4'd1;
               2'd1: key = 4'd4;
               2'd2: key = 4'd7;
               default: key = KEY_STAR;
            endcase
         end
         2'd1: begin
            unique case (row)
               2'd0: key = 4'd2;
               2'd1: key = 4'd5;
               2'd2: key = 4'd8;
               default: key = 4'd0;
            endcase
         end
         2'd2: begin
            unique case (row)
               2'd0: key = 4'd3;
               2'd1: key = 4'd6;
               2'd2: key = 4'd9;
               default: key = KEY_HASH;
            endcase
         end
         default: key = KEY_EMPTY;
      endcase
      return key;
   endfunction

endpackage

// File: design/kcl_step.sv
// Combinational press handling: hold window, key decode, entry and code judgment.
`timescale 1ns / 1ps

module kcl_step
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = 4,
   parameter int LEN_W = $clog2(CODE_DIGITS + 1)
) (
   input  cfg_type          cfg,
   input  press_type        press,
   input  ctrl_type         ctrl_cur,
   input  logic [LEN_W-1:0] len_cur,
   input  logic [3:0]       store_cur [CODE_DIGITS],
   input  logic [3:0]       user_cur [CODE_DIGITS],
   output ctrl_type         ctrl_next,
   output logic [LEN_W-1:0] len_next,
   output logic [3:0]       store_next [CODE_DIGITS],
   output logic [3:0]       user_next [CODE_DIGITS],
   output result_type       result
);

   localparam int SHOW_N = (CODE_DIGITS < 4) ? CODE_DIGITS : 4;

   logic [3:0]  key;
   logic [31:0] elapsed;
   logic        take;
   logic        full;
   logic        user_match;
   logic        svc_match;
   logic [31:0] svc_wide;
   logic [10:0] hold_flash;
   logic [15:0] shown;
   event_type   ev;
   logic [3:0]  entry_new [CODE_DIGITS];

   always_comb begin
      ctrl_next  = ctrl_cur;
      len_next   = len_cur;
      store_next = store_cur;
      user_next  = user_cur;
      ev         = EV_IGNORED;

      // Decode the key and test the hold window with wraparound subtraction.
      key     = key_decode(press.key_column, press.key_row);
      elapsed = press.now_ms - ctrl_cur.last_time;
      take    = (press.key_column != COL_NONE) && (elapsed > 32'(ctrl_cur.hold_window));

      // Entry as it stands with the new digit placed at the fill position.
      for (int i = 0; i < CODE_DIGITS; i++) begin
         entry_new[i] = (LEN_W'(i) == len_cur) ? key : store_cur[i];
      end
      full = (len_cur == LEN_W'(CODE_DIGITS - 1));

      // Compare the completed entry with both codes.
      svc_wide   = {cfg.service_code, 16'h0000};
      user_match = 1'b1;
      svc_match  = 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (entry_new[i] != user_cur[i]) begin
            user_match = 1'b0;
         end
         if (entry_new[i] != svc_wide[4*(7-i) +: 4]) begin
            svc_match = 1'b0;
         end
      end

      hold_flash = 11'(cfg.debounce_ms) + 11'(cfg.flash_ms);

      if (take) begin
         ctrl_next.last_time   = press.now_ms;
         ctrl_next.hold_window = 11'(cfg.debounce_ms);
         if (key <= 4'd9) begin
            // Digit: store it, and judge the entry once it is complete.
            ev = EV_DIGIT;
            if (full) begin
               if (ctrl_cur.check_armed) begin
                  if (user_match) begin
                     ev = EV_OPEN;
                     ctrl_next.hold_window = hold_flash;
                  end else if (svc_match) begin
                     ev = EV_SERVICE;
                     ctrl_next.in_service = 1'b1;
                  end else begin
                     ev = EV_WRONG;
                     ctrl_next.hold_window = hold_flash;
                  end
                  ctrl_next.check_armed = 1'b0;
               end else if (ctrl_cur.in_service) begin
                  user_next             = entry_new;
                  ctrl_next.in_service  = 1'b0;
                  ev                    = EV_CHANGED;
                  ctrl_next.hold_window = hold_flash;
               end else begin
                  ev = EV_WRONG;
                  ctrl_next.hold_window = hold_flash;
               end
               for (int i = 0; i < CODE_DIGITS; i++) begin
                  store_next[i] = KEY_EMPTY;
               end
               len_next = '0;
            end else begin
               store_next = entry_new;
               len_next   = len_cur + LEN_W'(1);
            end
         end else if (key == KEY_STAR) begin
            // Star arms the check on an empty entry, or leaves service mode.
            ev = EV_NONE;
            if (len_cur == '0) begin
               ctrl_next.check_armed = 1'b1;
            end
            if (ctrl_cur.in_service) begin
               ctrl_next.in_service  = 1'b0;
               ctrl_next.check_armed = 1'b0;
               for (int i = 0; i < CODE_DIGITS; i++) begin
                  store_next[i] = KEY_EMPTY;
               end
               len_next = '0;
               ev       = EV_CANCEL_STAR;
            end
         end else begin
            // Hash leaves service mode, or clears a partial entry.
            if (ctrl_cur.in_service) begin
               ctrl_next.in_service = 1'b0;
               ev = EV_CANCEL_HASH;
            end else if (len_cur != '0) begin
               for (int i = 0; i < CODE_DIGITS; i++) begin
                  store_next[i] = KEY_EMPTY;
               end
               len_next = '0;
               ev       = EV_CLEARED;
            end else begin
               ev = EV_NONE;
            end
         end
      end

      // Show the first four held places, empty beyond the code length.
      shown = {4{KEY_EMPTY}};
      for (int i = 0; i < SHOW_N; i++) begin
         shown[4*(3-i) +: 4] = store_next[i];
      end

      result.accepted     = take;
      result.key_value    = take ? key : 4'd0;
      result.event_res    = ev;
      result.steady_leds  = ctrl_next.in_service ? LEDS_SERVICE : LEDS_OFF;
      result.entry_count  = 3'(len_next);
      result.entry_digits = shown;
   end

endmodule

// File: design/keypad_code_lock_unit.sv
// Top level of the keypad code lock: channels, registers and configuration.
`timescale 1ns / 1ps
//
// Keypad code lock. Each transfer on the req_ channel is one keypad press
// (column, row, millisecond time stamp); each press gives exactly one
// transfer on the rsp_ channel with the press outcome, the lamp state and
// the digits held. Configuration registers (debounce time, flash time,
// service code) are written over the csr_ channel, which is always ready,
// and should be written only while no press is in flight.
// A press accepted into the input register is judged combinationally from
// that register and loaded into the result register, which drives rsp_tvalid.
// Throughput: one press per cycle while the rsp_ receiver does not stall; the
// lock state read by a press is the state left by the press before it,
// updated when that press is judged. A stalled rsp_ receiver holds the result
// register; the input register keeps taking a press until it too is full,
// then req_tready drops.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults, the user code and the hold window, and clears the entry.
//
`include "assert_macros.svh"

module keypad_code_lock_unit
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Press channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // key_column[1:0], key_row[3:2], now_ms[35:4], zero[39:36]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // accepted[0], key_value[4:1], event_res[8:5],
                                    // steady_leds[11:9], entry_count[14:12],
                                    // entry_digits[30:15], zero[31]
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int LEN_W = $clog2(CODE_DIGITS + 1);

   logic             in_valid_ff, in_valid_in;
   press_type        in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;
   cfg_type          cfg_ff, cfg_in;
   ctrl_type         ctrl_ff, ctrl_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [3:0]       store_ff [CODE_DIGITS];
   logic [3:0]       store_in [CODE_DIGITS];
   logic [3:0]       user_ff [CODE_DIGITS];
   logic [3:0]       user_in [CODE_DIGITS];
   result_type       step_result;
   logic             stage_fire;
   logic             req_fire;
   logic             rsp_fire;

   // Handshake: the judge stage moves when it holds a press and the result register can take a value.
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign stage_fire = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || stage_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // Press judgment on the registered press.
   kcl_step #(
      .CODE_DIGITS (CODE_DIGITS),
      .LEN_W       (LEN_W)
   ) u_step (
      .cfg        (cfg_ff),
      .press      (in_data_ff),
      .ctrl_cur   (ctrl_ff),
      .len_cur    (len_ff),
      .store_cur  (store_ff),
      .user_cur   (user_ff),
      .ctrl_next  (ctrl_in),
      .len_next   (len_in),
      .store_next (store_in),
      .user_next  (user_in),
      .result     (step_result)
   );

   // Valid flags of the two registers.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (stage_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration register decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ms  = csr_data[9:0];
            CSR_FLASH:    cfg_in.flash_ms     = csr_data[9:0];
            CSR_SERVICE:  cfg_in.service_code = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // Channel and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         cfg_ff.debounce_ms  <= DEBOUNCE_RESET;
         cfg_ff.flash_ms     <= FLASH_RESET;
         cfg_ff.service_code <= SERVICE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= press_type'(req_tdata[35:0]);
      end
      if (stage_fire) begin
         rsp_data_ff <= step_result;
      end
   end

   // Lock state, updated once per judged press.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.check_armed <= 1'b0;
         ctrl_ff.in_service  <= 1'b0;
         ctrl_ff.last_time   <= '0;
         ctrl_ff.hold_window <= HOLD_RESET;
         len_ff              <= '0;
         for (int i = 0; i < CODE_DIGITS; i++) begin
            store_ff[i] <= KEY_EMPTY;
            user_ff[i]  <= (i < 4) ? USER_RESET[4*(3-i) +: 4] : 4'd0;
         end
      end else if (stage_fire) begin
         ctrl_ff  <= ctrl_in;
         len_ff   <= len_in;
         store_ff <= store_in;
         user_ff  <= user_in;
      end
   end

   // Design checks.
   `KCL_ASSERT_SAME(a_len_short, clock, reset, 1'b1, len_ff < LEN_W'(CODE_DIGITS),
      "entry holds a full code between presses")
   `KCL_ASSERT_NEXT(a_stage_loads, clock, reset, stage_fire, rsp_valid_ff,
      "judged press did not reach the result register")
   `KCL_ASSERT_SAME(a_ignored_clean, clock, reset,
      rsp_valid_ff && !rsp_data_ff.accepted,
      rsp_data_ff.event_res == EV_IGNORED && rsp_data_ff.key_value == 4'd0,
      "ignored press carries a key or an event")
   `KCL_ASSERT_SAME(a_service_entry, clock, reset, $rose(ctrl_ff.in_service),
      rsp_data_ff.event_res == EV_SERVICE,
      "service mode entered without a service code match")

endmodule
